>>> design/xor_checked_set_assoc_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash table unit
// Concurrent checks sampled on aclk, muted while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_SET_ASSOC_HASH_TABLE_UNIT_MACROS_SVH
`define XOR_CHECKED_SET_ASSOC_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define XCSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/xcsa_pkg.sv
// ----------------------------------------------------------------------------
// xcsa_pkg
// Request/result types, operation and register codes for the hash table.
// ----------------------------------------------------------------------------
package xcsa_pkg;

    localparam int HASH_W    = 64;
    localparam int DATA_W    = 64;
    localparam int ENTRY_W   = HASH_W + DATA_W;   // {check, data}
    localparam int FLAG_W    = 2;
    localparam int DEPTH_W   = 8;
    localparam int PAYLOAD_W = 54;
    localparam int CFG_W     = 32;
    localparam int PADDR_W   = 3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic REG_TABLE_ENABLE = 1'b0;
    localparam logic REG_INDEX_BITS   = 1'b1;

    typedef struct packed {
        logic [1:0]           operation;
        logic [HASH_W-1:0]    position_hash;
        logic [FLAG_W-1:0]    new_flag;
        logic [DEPTH_W-1:0]   new_depth;
        logic [PAYLOAD_W-1:0] new_payload;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic [FLAG_W-1:0]    found_flag;
        logic [DEPTH_W-1:0]   found_depth;
        logic [PAYLOAD_W-1:0] found_payload;
        logic                 stored;
    } rsp_t;

    // status of the way scan
    typedef struct packed {
        logic match;   // read hit, or write found its own entry
        logic drop;    // write found a deeper entry of the same kind
    } scan_st_t;

endpackage

>>> design/xcsa_row_mem.sv
// ----------------------------------------------------------------------------
// xcsa_row_mem
// One cluster row per word; one write port, one registered read port.
// ----------------------------------------------------------------------------
module xcsa_row_mem #(
    parameter int ADDR_W = 10,
    parameter int ROW_W  = 512
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/xcsa_way_scan.sv
// ----------------------------------------------------------------------------
// xcsa_way_scan
// Shared check/replace unit: evaluates one way per step.
// ----------------------------------------------------------------------------
module xcsa_way_scan
    import xcsa_pkg::*;
#(
    parameter int WAY_W     = 2,
    parameter int MAX_DEPTH = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                step,
    input  logic                is_write,
    input  logic [HASH_W-1:0]   hash,
    input  logic [FLAG_W-1:0]   new_flag,
    input  logic [DEPTH_W-1:0]  new_depth,
    input  logic [WAY_W-1:0]    way_idx,
    input  logic [HASH_W-1:0]   way_check,
    input  logic [DATA_W-1:0]   way_data,
    output scan_st_t            st,
    output logic [WAY_W-1:0]    target,
    output logic [DATA_W-1:0]   hit_data
);

    scan_st_t           st_reg, st_next;
    logic [WAY_W-1:0]   target_reg, target_next;
    logic [DEPTH_W-1:0] mind_reg, mind_next;
    logic [DATA_W-1:0]  hit_reg, hit_next;
    logic               eq;
    logic [FLAG_W-1:0]  w_flag;
    logic [DEPTH_W-1:0] w_depth;

    assign eq      = ((way_check ^ way_data) == hash);
    assign w_flag  = way_data[FLAG_W-1:0];
    assign w_depth = way_data[FLAG_W +: DEPTH_W];

    always_comb begin
        st_next     = st_reg;
        target_next = target_reg;
        mind_next   = mind_reg;
        hit_next    = hit_reg;
        if (start) begin
            st_next     = '0;
            target_next = '0;
            mind_next   = DEPTH_W'(MAX_DEPTH);
        end else if (step && !is_write) begin
            if (eq && (w_flag != '0)) begin
                st_next.match = 1'b1;
                hit_next      = way_data;
            end
        end else if (step) begin
            if (eq && (w_flag == new_flag)) begin
                st_next.match = 1'b1;
                if (w_depth > new_depth) begin
                    st_next.drop = 1'b1;
                end else begin
                    target_next = way_idx;
                end
            end else if (w_depth < mind_reg) begin
                mind_next   = w_depth;
                target_next = way_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
        target_reg <= target_next;
        mind_reg   <= mind_next;
        hit_reg    <= hit_next;
    end

    assign st       = st_reg;
    assign target   = target_reg;
    assign hit_data = hit_reg;

endmodule

>>> design/xor_checked_set_assoc_hash_table_unit.sv
// ----------------------------------------------------------------------------
// xor_checked_set_assoc_hash_table_unit
// Set-associative hash table, xor-checked entries, depth-preferred replace.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel takes one request (read, write or clear), m_ channel returns
//    one result per request, in order. Both are valid/ready.
//  - APB port: register 0 table_enable at 0x0, register 1 index_bits at 0x4.
//    Write only while the unit is idle.
//  - Read/write: the cluster row is fetched from the row memory, then one
//    shared check unit walks the ways, one way a cycle, stopping at a match.
//    States in order: READ (row fetch), SCAN (way walk), DONE; the result
//    is registered when DONE finds the result slot free.
//    Disabled table or a zero write flag: READ goes straight to DONE;
//    unused operation: straight from IDLE to DONE.
//  - Clear: one memory row zeroed per cycle, all 2^MAX_INDEX_BITS rows.
//  - Reset: registers go to 0 and a clearing pass over all 2^MAX_INDEX_BITS
//    rows runs; s_ready stays low until it ends (APB is served).
//  - Receiver stall: the result is held in the output register; the unit
//    still takes and works one more request, then waits in DONE.
// ----------------------------------------------------------------------------
`include "xor_checked_set_assoc_hash_table_unit_macros.svh"

module xor_checked_set_assoc_hash_table_unit
    import xcsa_pkg::*;
#(
    parameter int WAYS           = 4,
    parameter int MAX_INDEX_BITS = 10,
    parameter int MAX_DEPTH      = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output rsp_t               m_data,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * ENTRY_W;
    localparam int AW    = MAX_INDEX_BITS;

    // sequencer
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           clr_rsp_reg, clr_rsp_next;
    logic [WAY_W-1:0] way_reg, way_next;
    req_t           req_reg;
    logic           active_reg;
    logic [AW-1:0]  addr_reg;

    // config
    logic           enable_reg;
    logic [3:0]     ibits_reg;

    // result register
    logic           m_valid_reg;
    rsp_t           m_data_reg;

    // datapath
    logic [AW-1:0]  cl_mask;
    logic [ROW_W-1:0] row_q, wb_row;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] cur_entry;
    logic [DATA_W-1:0]  new_data;
    logic           is_write, is_read, out_free, accept;
    logic           scan_start, scan_step, last_way;
    scan_st_t       sst;
    logic [WAY_W-1:0]   s_target;
    logic [DATA_W-1:0]  s_hit;
    logic           cfg_wr;
    rsp_t           rsp;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_write = (req_reg.operation == OP_WRITE);
    assign is_read  = (req_reg.operation == OP_READ);

    // cluster mask from index_bits; saturation falls out of the mask width
    always_comb begin
        for (int i = 0; i < AW; i++) begin
            cl_mask[i] = ({1'b0, ibits_reg} > 5'(i));
        end
    end

    assign cur_entry = row_q[way_reg*ENTRY_W +: ENTRY_W];
    assign last_way  = (way_reg == WAY_W'(WAYS-1));
    assign new_data  = {req_reg.new_payload, req_reg.new_depth, req_reg.new_flag};

    always_comb begin
        wb_row = row_q;
        wb_row[s_target*ENTRY_W +: ENTRY_W] = {req_reg.position_hash ^ new_data, new_data};
    end

    // result of the current request
    always_comb begin
        rsp = '0;
        if (is_read && active_reg && sst.match) begin
            rsp.found         = 1'b1;
            rsp.found_flag    = s_hit[FLAG_W-1:0];
            rsp.found_depth   = s_hit[FLAG_W +: DEPTH_W];
            rsp.found_payload = s_hit[FLAG_W+DEPTH_W +: PAYLOAD_W];
        end
        rsp.stored = is_write && active_reg && !sst.drop;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_rsp_next = clr_rsp_reg;
        way_next     = way_reg;
        scan_start   = 1'b0;
        scan_step    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = wb_row;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {AW{1'b1}}) begin
                    state_next = clr_rsp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    clr_cnt_next = '0;
                    clr_rsp_next = 1'b1;
                    unique case (s_data.operation)
                        OP_CLEAR:          state_next = ST_CLEAR;
                        OP_READ, OP_WRITE: state_next = ST_READ;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                // row is fetched this cycle; idle requests skip the scan
                scan_start = 1'b1;
                way_next   = '0;
                state_next = active_reg ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                scan_step = 1'b1;
                way_next  = way_reg + 1'b1;
                if (last_way) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // write back the row and return to idle; wait for a free result slot
                if (out_free) begin
                    mem_we     = is_write && active_reg && !sst.drop;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // a matching way ends the scan at once
        if (state_reg == ST_SCAN && sst.match) begin
            scan_step  = 1'b0;
            state_next = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_rsp_reg <= 1'b0;
            way_reg     <= '0;
            active_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_rsp_reg <= clr_rsp_next;
            way_reg     <= way_next;
            if (accept) begin
                active_reg <= enable_reg &&
                              ((s_data.operation == OP_READ) ||
                               ((s_data.operation == OP_WRITE) && (s_data.new_flag != '0)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_data;
            addr_reg <= s_data.position_hash[AW-1:0] & cl_mask;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= rsp;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // config registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            ibits_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TABLE_ENABLE: enable_reg <= pwdata[0];
                REG_INDEX_BITS:   ibits_reg  <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TABLE_ENABLE: prdata = {{(CFG_W-1){1'b0}}, enable_reg};
            REG_INDEX_BITS:   prdata = {{(CFG_W-4){1'b0}}, ibits_reg};
            default:          prdata = '0;
        endcase
    end

    // row store and shared way unit
    xcsa_row_mem #(
        .ADDR_W (AW),
        .ROW_W  (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (addr_reg),
        .rd_data (row_q)
    );

    xcsa_way_scan #(
        .WAY_W     (WAY_W),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .step      (scan_step),
        .is_write  (is_write),
        .hash      (req_reg.position_hash),
        .new_flag  (req_reg.new_flag),
        .new_depth (req_reg.new_depth),
        .way_idx   (way_reg),
        .way_check (cur_entry[ENTRY_W-1 -: HASH_W]),
        .way_data  (cur_entry[DATA_W-1:0]),
        .st        (sst),
        .target    (s_target),
        .hit_data  (s_hit)
    );

    // checks
    `XCSA_ASSERT_NOW(a_we_state, mem_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_DONE), "row write outside clear/done")
    `XCSA_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "ready right after a request")
    `XCSA_ASSERT_NOW(a_found_flag, m_valid && m_data.found,
        m_data.found_flag != '0, "hit reported with zero flag")
    `XCSA_ASSERT_NOW(a_found_xor_stored, m_valid,
        !(m_data.found && m_data.stored), "result both hit and stored")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: hash table unit bench
// Drives read, write, clear and unused requests into the set-associative
// table, shadows the check and data stores in a local copy and compares every
// result field by field. A short directed table comes first, then random
// phases over several table_enable / index_bits settings, with bursty
// requests, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import xcsa_pkg::*;

    localparam int NUM_WAYS       = 4;
    localparam int IDX_LIMIT      = 10;
    localparam int DEPTH_CEIL     = 255;
    localparam int NUM_ENTRIES    = (1 << IDX_LIMIT) * NUM_WAYS;
    localparam int POOL_SIZE      = 12;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 66;
    localparam int MAX_PRINTS     = 40;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // request / result channels
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // config port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [CFG_W-1:0]   pwdata  = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    xor_checked_set_assoc_hash_table_unit #(
        .WAYS           (NUM_WAYS),
        .MAX_INDEX_BITS (IDX_LIMIT),
        .MAX_DEPTH      (DEPTH_CEIL)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow of the table: stores, registers, results still owed
    // ------------------------------------------------------------------------
    logic [63:0] shadow_check [NUM_ENTRIES] = '{default: '0};
    logic [63:0] shadow_data  [NUM_ENTRIES] = '{default: '0};
    logic        shadow_enable     = 1'b0;
    logic [3:0]  shadow_index_bits = 4'd0;
    rsp_t        owed_results [$];
    int          error_count = 0;

    // hashes reused across requests so reads hit and writes compete for ways
    logic [63:0] hash_pool [POOL_SIZE];
    logic [9:0]  hot_cluster [3];

    // settings walked by the random phases; extremes and an oversized index
    bit          phase_enable [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic [3:0]  phase_index  [PHASES] = '{4'd10, 4'd1, 4'd15, 4'd3, 4'd0, 4'd4};

    // directed stimulus table
    typedef struct {
        req_t req;
        bit   fixed;   // expected result typed in below, not predicted
        rsp_t want;
    } stim_row_t;

    stim_row_t directed_rows [$];

    // receiver hold-off handshake between main flow and receiver process
    int unsigned holdoff_seq  = 0;
    int unsigned holdoff_seen = 0;
    int unsigned holdoff_left = 0;
    int unsigned rx_mode      = 0;
    int unsigned rx_span      = 0;
    int unsigned rx_tick      = 0;
    int unsigned cycle_count  = 0;

    // Work out one request against the shadow table and return its result.
    // Clear wipes everything; read takes first valid way whose check ^ data
    // equals the hash; write replaces its own entry unless that is deeper,
    // else the shallowest way below the depth ceiling, else way 0.
    function automatic rsp_t shadow_apply(input req_t r);
        rsp_t        res;
        logic [63:0] d;
        logic [63:0] nd;
        logic [63:0] set_mask;
        int unsigned ib;
        int unsigned base;
        int unsigned tgt;
        int unsigned shallowest;
        bit          decided;
        bit          dropped;
        res = '0;
        // oversized index saturates
        ib = (shadow_index_bits > IDX_LIMIT) ? IDX_LIMIT : shadow_index_bits;
        set_mask = (64'd1 << ib) - 64'd1;
        base = 32'(r.position_hash & set_mask) * NUM_WAYS;
        case (op_t'(r.operation))
            OP_CLEAR: begin
                // clear works even with the table disabled
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    shadow_check[i] = '0;
                    shadow_data[i]  = '0;
                end
            end
            OP_READ: begin
                if (shadow_enable) begin
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        d = shadow_data[base + w];
                        if (!res.found && d[1:0] != 2'd0 &&
                            (shadow_check[base + w] ^ d) == r.position_hash) begin
                            res.found         = 1'b1;
                            res.found_flag    = d[1:0];
                            res.found_depth   = d[9:2];
                            res.found_payload = d[63:10];
                        end
                    end
                end
            end
            OP_WRITE: begin
                // zero flag is not a valid bound type: ignored
                if (shadow_enable && r.new_flag != 2'd0) begin
                    nd         = {r.new_payload, r.new_depth, r.new_flag};
                    tgt        = 0;
                    shallowest = DEPTH_CEIL;
                    decided    = 1'b0;
                    dropped    = 1'b0;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        d = shadow_data[base + w];
                        if (!decided) begin
                            if ((shadow_check[base + w] ^ d) == r.position_hash &&
                                d[1:0] == r.new_flag) begin
                                decided = 1'b1;
                                if (d[9:2] > r.new_depth)
                                    dropped = 1'b1;
                                else
                                    tgt = w;
                            end else if (d[9:2] < shallowest) begin
                                shallowest = d[9:2];
                                tgt        = w;
                            end
                        end
                    end
                    if (!dropped) begin
                        shadow_check[base + tgt] = r.position_hash ^ nd;
                        shadow_data[base + tgt]  = nd;
                        res.stored               = 1'b1;
                    end
                end
            end
            default: ;   // unused operation: nothing changes
        endcase
        return res;
    endfunction

    function automatic req_t make_req(input op_t op, input logic [63:0] h,
                                      input logic [1:0] f, input logic [7:0] d,
                                      input logic [53:0] p);
        req_t r;
        r.operation     = op;
        r.position_hash = h;
        r.new_flag      = f;
        r.new_depth     = d;
        r.new_payload   = p;
        return r;
    endfunction

    // replace half the pool; pool hashes share a few hot clusters
    function automatic void refresh_pool();
        for (int i = 0; i < 3; i++)
            hot_cluster[i] = 10'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 1) == 0 || hash_pool[i] === 64'bx) begin
                hash_pool[i]      = {$urandom, $urandom};
                hash_pool[i][9:0] = hot_cluster[$urandom_range(0, 2)];
            end
        end
    endfunction

    function automatic req_t random_req();
        req_t        r;
        logic [63:0] raw;
        int unsigned pick;
        r.position_hash = {$urandom, $urandom};
        raw             = {$urandom, $urandom};
        r.new_payload   = raw[53:0];
        r.new_flag      = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.operation = OP_READ;
        else if (pick < 91)
            r.operation = OP_WRITE;
        else if (pick < 93)
            r.operation = OP_CLEAR;   // long pass, kept rare
        else
            r.operation = OP_NONE;
        if (r.operation == OP_READ || r.operation == OP_WRITE) begin
            if ($urandom_range(0, 3) != 0)
                r.position_hash = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        if (r.operation == OP_WRITE)
            r.new_flag = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.new_depth = 8'd0;
        else if (pick < 4)
            r.new_depth = 8'(DEPTH_CEIL);
        else
            r.new_depth = 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.new_payload = '0;
        else if (pick < 3)
            r.new_payload = '1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one request; called in the step of a rising edge, returns in the
    // step of the edge that accepted it. Valid stays high for the caller.
    task automatic offer(input req_t r, input bit fixed, input rsp_t want);
        rsp_t predicted;
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = shadow_apply(r);
        owed_results.push_back(fixed ? want : predicted);
    endtask

    // stop sending until every owed result has come back
    task automatic wait_until_answered();
        s_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
    endtask

    // APB write: setup phase, access phase, then the bus goes idle
    task automatic write_reg(input logic idx, input logic [3:0] val);
        logic [CFG_W-1:0] word;
        word = $urandom;   // upper bits are don't-care
        if (idx == REG_TABLE_ENABLE)
            word[0] = val[0];
        else
            word[3:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TABLE_ENABLE)
            shadow_enable = word[0];
        else
            shadow_index_bits = word[3:0];
        @(posedge aclk);
    endtask

    // bursts of random length, random gaps; optional long receiver hold-off
    task automatic run_random_phase(input int n_items, input bit with_holdoff);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < n_items) begin
                if (with_holdoff && sent == n_items / 3)
                    holdoff_seq <= holdoff_seq + 1;
                offer(random_req(), 1'b0, '0);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, redrawn whenever its span runs out, plus the
    // long hold-off on request from the main flow.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (holdoff_seen != holdoff_seq) begin
            holdoff_seen <= holdoff_seq;
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready      <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready      <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_span <= $urandom_range(20, 80);
            end else begin
                rx_span <= rx_span - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;                          // no stalls
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_tick[1:0] == 2'd0);        // one in four
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result with no request owed", 64'(m_data.stored), '0);
            end else begin
                want = owed_results.pop_front();
                if (m_data.found !== want.found)
                    report_mismatch("found", 64'(m_data.found), 64'(want.found));
                if (m_data.found_flag !== want.found_flag)
                    report_mismatch("found_flag", 64'(m_data.found_flag),
                                    64'(want.found_flag));
                if (m_data.found_depth !== want.found_depth)
                    report_mismatch("found_depth", 64'(m_data.found_depth),
                                    64'(want.found_depth));
                if (m_data.found_payload !== want.found_payload)
                    report_mismatch("found_payload", 64'(m_data.found_payload),
                                    64'(want.found_payload));
                if (m_data.stored !== want.stored)
                    report_mismatch("stored", 64'(m_data.stored), 64'(want.stored));
            end
        end
    end

    // run limit; covers the clearing pass after reset and every clear
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** xor_checked_set_assoc_hash_table_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------------
    initial begin
        int          first_enabled_row;
        logic [63:0] h1;
        logic [63:0] ones;
        rsp_t        none;
        h1   = 64'hA5A5_5A5A_0F0F_F0F1;   // cluster 1 with two index bits
        ones = '1;
        none = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            hash_pool[i] = 64'bx;

        // table disabled out of reset: everything answers zero
        directed_rows.push_back('{make_req(OP_READ, 64'd0, 2'd0, 8'd0, 54'd0), 1'b1, none});
        directed_rows.push_back('{make_req(OP_WRITE, ones, 2'd3, 8'hFF, '1), 1'b1, none});
        directed_rows.push_back('{make_req(OP_READ, ones, 2'd3, 8'hFF, '1), 1'b1, none});
        directed_rows.push_back('{make_req(OP_NONE, ones, 2'd3, 8'hFF, '1), 1'b1, none});
        directed_rows.push_back('{make_req(OP_CLEAR, ones, 2'd3, 8'hFF, '1), 1'b1, none});
        first_enabled_row = directed_rows.size();
        // enabled, four clusters: zeroed entries must not hit hash 0
        directed_rows.push_back('{make_req(OP_READ, 64'd0, 2'd0, 8'd0, 54'd0), 1'b1, none});
        directed_rows.push_back('{make_req(OP_WRITE, 64'd0, 2'd1, 8'd0, 54'd0), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, 64'd0, 2'd0, 8'd0, 54'd0), 1'b0, none});
        directed_rows.push_back('{make_req(OP_WRITE, ones, 2'd3, 8'hFF, '1), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, ones, 2'd0, 8'd0, 54'd0), 1'b0, none});
        // own entry: shallower write dropped, equal depth replaces, other flag
        // takes another way
        directed_rows.push_back('{make_req(OP_WRITE, h1, 2'd1, 8'd10, 54'h1234_5678_9ABCD),
                                  1'b0, none});
        directed_rows.push_back('{make_req(OP_WRITE, h1, 2'd1, 8'd5, 54'h3), 1'b0, none});
        directed_rows.push_back('{make_req(OP_WRITE, h1, 2'd1, 8'd10, 54'h2AA_AAAA_5555),
                                  1'b0, none});
        directed_rows.push_back('{make_req(OP_WRITE, h1, 2'd2, 8'd0, 54'h77), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, h1, 2'd0, 8'd0, 54'd0), 1'b0, none});
        // zero write flag and unused operation with the table on
        directed_rows.push_back('{make_req(OP_WRITE, h1, 2'd0, 8'd200, 54'h55), 1'b1, none});
        directed_rows.push_back('{make_req(OP_NONE, h1, 2'd2, 8'd9, 54'h99), 1'b1, none});
        // full-depth entries fill every way of cluster 1, overwriting the h1 entries
        for (int i = 0; i < 4; i++)
            directed_rows.push_back('{make_req(OP_WRITE, 64'h1111_2222_3333_0005 + 4 * i,
                                               2'd3, 8'hFF, 54'(i + 1)), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, 64'h1111_2222_3333_0005, 2'd0, 8'd0,
                                           54'd0), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, 64'h1111_2222_3333_0011, 2'd0, 8'd0,
                                           54'd0), 1'b0, none});
        directed_rows.push_back('{make_req(OP_READ, h1, 2'd0, 8'd0, 54'd0), 1'b0, none});
        directed_rows.push_back('{make_req(OP_CLEAR, 64'd0, 2'd0, 8'd0, 54'd0), 1'b1, none});
        directed_rows.push_back('{make_req(OP_READ, h1, 2'd0, 8'd0, 54'd0), 1'b1, none});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part; registers set once the disabled rows are answered
        foreach (directed_rows[i]) begin
            if (i == first_enabled_row) begin
                wait_until_answered();
                write_reg(REG_TABLE_ENABLE, 4'd1);
                write_reg(REG_INDEX_BITS, 4'd2);
            end
            offer(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);
        end

        // random phases; registers only touched once every request is answered
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_until_answered();
            write_reg(REG_TABLE_ENABLE, {3'd0, phase_enable[ph]});
            write_reg(REG_INDEX_BITS, phase_index[ph]);
            refresh_pool();
            run_random_phase(PHASE_ITEMS, ph == 0);
        end

        wait_until_answered();
        repeat (16) @(posedge aclk);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("** xor_checked_set_assoc_hash_table_unit: PASSED **");
        end else begin
            $display("** xor_checked_set_assoc_hash_table_unit: FAILED **");
        end
        $finish;
    end

endmodule
